FILE: design/ccts_pkg.sv
// package for the cyclic can transmit scheduler
// holds command codes, sequencer states, the entry record and the dlc mapping
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ccts_pkg;

  // slot and index fields are 4 bits wide, so the table size is fixed here
  localparam int unsigned TABLE_DEPTH = 16;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_UPDATE = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_CLEAR  = 3'd4,
    KIND_START  = 3'd5,
    KIND_STOP   = 3'd6,
    KIND_SEND   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_PREP,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    logic        fd;
    logic        brs;
    logic [6:0]  len;
    logic [15:0] period;
    logic        paused;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);
  localparam int unsigned TIME_W  = 48;
  localparam logic [TIME_W-1:0] TIME_ALL_ONES = '1;

  // fd dlc code from byte length
  function automatic logic [6:0] len_to_code(input logic [6:0] len);
    logic [6:0] code;
    if (len <= 7'd8) code = len;
    else if (len <= 7'd12) code = 7'd9;
    else if (len <= 7'd16) code = 7'd10;
    else if (len <= 7'd20) code = 7'd11;
    else if (len <= 7'd24) code = 7'd12;
    else if (len <= 7'd32) code = 7'd13;
    else if (len <= 7'd48) code = 7'd14;
    else code = 7'd15;
    return code;
  endfunction

endpackage
`default_nettype wire

FILE: design/ccts_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ccts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/can_cyclic_tx_scheduler.sv
// cyclic can transmit scheduler top level
// depends on ccts_pkg and ccts_ram (entry table and due time table)
//
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_stall  | kind, index, time, entry contents
// out_    | out | out_valid/out_stall| slot, id, flags, dlc, length, last
// cfg_    | in  | cfg_we             | port_open bit
//
// add and update go through the write state; clear, stop and refused commands stay
// in idle; tick runs prep, an eval per entry and flush, start prep and an eval per entry,
// one table entry per cycle (for tick only while a firing entry can park the held frame)
// through the shared due-time compare/add unit and the single read port of each table ram
// remove runs prep and an eval per entry above the removed slot, send_now prep, eval, flush
// a stalled result holds the tick walk at the next firing entry
// reset clears count, sending, port_open and the handshake state; tables need no clear
`timescale 1ns / 1ps
`default_nettype none
module can_cyclic_tx_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [3:0]  in_entry_index,
  input  wire logic [47:0] in_now_ms,
  input  wire logic [28:0] in_can_id,
  input  wire logic        in_extended,
  input  wire logic        in_remote,
  input  wire logic        in_flexible_rate,
  input  wire logic        in_bit_rate_switch,
  input  wire logic [6:0]  in_byte_length,
  input  wire logic [15:0] in_period_ms,
  input  wire logic        in_paused,
  // frame items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_slot,
  output logic [28:0]      out_id,
  output logic             out_extended,
  output logic             out_remote,
  output logic             out_fd,
  output logic             out_brs,
  output logic [6:0]       out_dlc_code,
  output logic [6:0]       out_length,
  output logic             out_last,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);

  localparam int unsigned TABLE_DEPTH = ccts_pkg::TABLE_DEPTH;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = (CW > 4) ? CW : 4;
  localparam int unsigned TW = ccts_pkg::TIME_W;

  ccts_pkg::state_t state_r, state_nxt;
  ccts_pkg::kind_t  kind_r, kind_nxt, in_kind_e;
  logic [3:0]       idx_r, idx_nxt;
  logic [TW-1:0]    now_r, now_nxt;
  ccts_pkg::entry_t ent_r, ent_nxt, in_ent;
  logic [CW-1:0]    count_r, count_nxt;
  logic             sending_r, sending_nxt;
  logic             port_open_r, port_open_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt, ptr_inc;
  logic             hold_valid_r, hold_valid_nxt;
  ccts_pkg::entry_t hold_ent_r, hold_ent_nxt;
  logic [3:0]       hold_slot_r, hold_slot_nxt;

  logic             out_valid_r, out_valid_nxt;
  ccts_pkg::entry_t out_ent_r, out_ent_nxt;
  logic [3:0]       out_slot_r, out_slot_nxt;
  logic             out_last_r, out_last_nxt;

  // table rams
  logic             ent_we, due_we;
  logic [AW-1:0]    ent_waddr, due_waddr, raddr;
  ccts_pkg::entry_t ent_wdata, ent_rdata;
  logic [TW-1:0]    due_wdata, due_rdata;

  logic             accept, out_free;
  logic             idx_ok, room_ok, tick_go, start_go, send_go;
  logic             fire, can_go, walk_last, rm_last, prep_rm_last;
  logic [TW:0]      resched_sum;
  logic [TW-1:0]    resched;

  assign in_kind_e = ccts_pkg::kind_t'(in_kind);
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ccts_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_ent = '{id: in_can_id, ext: in_extended, rtr: in_remote, fd: in_flexible_rate,
                    brs: in_bit_rate_switch, len: in_byte_length, period: in_period_ms,
                    paused: in_paused};

  // admission checks on the incoming command
  assign idx_ok   = XW'(in_entry_index) < XW'(count_r);
  assign room_ok  = count_r < CW'(TABLE_DEPTH);
  assign tick_go  = port_open_r && sending_r && (count_r != '0);
  assign start_go = port_open_r && !sending_r;
  assign send_go  = port_open_r && idx_ok;

  // walk pointer bookkeeping
  assign ptr_inc      = ptr_r + 1'b1;
  assign walk_last    = ptr_inc >= count_r;
  assign rm_last      = ((CW + 1)'(ptr_inc) + 1'b1) >= (CW + 1)'(count_r);
  assign prep_rm_last = walk_last;

  // shared due-time unit: one compare and one saturating add per entry
  assign fire        = !ent_rdata.paused && !(now_r < due_rdata);
  assign resched_sum = {1'b0, now_r} + (TW + 1)'(ent_rdata.period);
  assign resched     = (ent_rdata.period == '0 || resched_sum[TW]) ?
                       ccts_pkg::TIME_ALL_ONES : resched_sum[TW-1:0];
  // a firing entry must park the previous hold in the output register first
  assign can_go      = !fire || !hold_valid_r || out_free;

  // read address follows the next pointer so data lines up with the eval cycle
  always_comb begin
    case (kind_r)
      ccts_pkg::KIND_REMOVE: raddr = AW'(ptr_nxt + 1'b1);
      ccts_pkg::KIND_SEND:   raddr = AW'(idx_r);
      default:               raddr = AW'(ptr_nxt);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccts_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_kind_e)
            ccts_pkg::KIND_TICK:   if (tick_go) state_nxt = ccts_pkg::ST_PREP;
            ccts_pkg::KIND_ADD:    if (room_ok) state_nxt = ccts_pkg::ST_WRITE;
            ccts_pkg::KIND_UPDATE: if (idx_ok) state_nxt = ccts_pkg::ST_WRITE;
            ccts_pkg::KIND_REMOVE: if (idx_ok) state_nxt = ccts_pkg::ST_PREP;
            ccts_pkg::KIND_START:  if (start_go && count_r != '0) state_nxt = ccts_pkg::ST_PREP;
            ccts_pkg::KIND_SEND:   if (send_go) state_nxt = ccts_pkg::ST_PREP;
            default:               state_nxt = ccts_pkg::ST_IDLE;
          endcase
        end
      end
      ccts_pkg::ST_WRITE: state_nxt = ccts_pkg::ST_IDLE;
      ccts_pkg::ST_PREP: begin
        if (kind_r == ccts_pkg::KIND_REMOVE && prep_rm_last) state_nxt = ccts_pkg::ST_IDLE;
        else state_nxt = ccts_pkg::ST_EVAL;
      end
      ccts_pkg::ST_EVAL: begin
        case (kind_r)
          ccts_pkg::KIND_TICK:   if (can_go && walk_last) state_nxt = ccts_pkg::ST_FLUSH;
          ccts_pkg::KIND_REMOVE: if (rm_last) state_nxt = ccts_pkg::ST_IDLE;
          ccts_pkg::KIND_START:  if (walk_last) state_nxt = ccts_pkg::ST_IDLE;
          default:               state_nxt = ccts_pkg::ST_FLUSH;
        endcase
      end
      ccts_pkg::ST_FLUSH: begin
        if (!hold_valid_r || out_free) state_nxt = ccts_pkg::ST_IDLE;
      end
      default: state_nxt = ccts_pkg::ST_IDLE;
    endcase
  end

  // datapath and ram controls
  always_comb begin
    kind_nxt       = kind_r;
    idx_nxt        = idx_r;
    now_nxt        = now_r;
    ent_nxt        = ent_r;
    count_nxt      = count_r;
    sending_nxt    = sending_r;
    port_open_nxt  = port_open_r;
    ptr_nxt        = ptr_r;
    hold_valid_nxt = hold_valid_r;
    hold_ent_nxt   = hold_ent_r;
    hold_slot_nxt  = hold_slot_r;
    out_valid_nxt  = out_valid_r;
    out_ent_nxt    = out_ent_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;
    ent_we         = 1'b0;
    due_we         = 1'b0;
    ent_waddr      = AW'(ptr_r);
    due_waddr      = AW'(ptr_r);
    ent_wdata      = ent_rdata;
    due_wdata      = due_rdata;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ccts_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind_e;
          idx_nxt  = in_entry_index;
          now_nxt  = in_now_ms;
          ent_nxt  = in_ent;
          ptr_nxt  = (in_kind_e == ccts_pkg::KIND_REMOVE) ? CW'(in_entry_index) : '0;
          case (in_kind_e)
            ccts_pkg::KIND_CLEAR: count_nxt = '0;
            ccts_pkg::KIND_START: if (start_go) sending_nxt = 1'b1;
            ccts_pkg::KIND_STOP:  sending_nxt = 1'b0;
            default:              sending_nxt = sending_r;
          endcase
        end
      end
      ccts_pkg::ST_WRITE: begin
        ent_we    = 1'b1;
        due_we    = 1'b1;
        ent_waddr = (kind_r == ccts_pkg::KIND_ADD) ? AW'(count_r) : AW'(idx_r);
        due_waddr = ent_waddr;
        ent_wdata = ent_r;
        due_wdata = '0;
        if (kind_r == ccts_pkg::KIND_ADD) count_nxt = count_r + 1'b1;
      end
      ccts_pkg::ST_PREP: begin
        if (kind_r == ccts_pkg::KIND_REMOVE && prep_rm_last) count_nxt = count_r - 1'b1;
      end
      ccts_pkg::ST_EVAL: begin
        case (kind_r)
          ccts_pkg::KIND_TICK: begin
            if (can_go) begin
              if (fire) begin
                due_we    = 1'b1;
                due_wdata = resched;
                if (hold_valid_r) begin
                  out_valid_nxt = 1'b1;
                  out_ent_nxt   = hold_ent_r;
                  out_slot_nxt  = hold_slot_r;
                  out_last_nxt  = 1'b0;
                end
                hold_valid_nxt = 1'b1;
                hold_ent_nxt   = ent_rdata;
                hold_slot_nxt  = 4'(ptr_r);
              end
              if (!walk_last) ptr_nxt = ptr_inc;
            end
          end
          ccts_pkg::KIND_REMOVE: begin
            // compact: slot ptr takes the contents of slot ptr + 1
            ent_we = 1'b1;
            due_we = 1'b1;
            if (rm_last) count_nxt = count_r - 1'b1;
            else ptr_nxt = ptr_inc;
          end
          ccts_pkg::KIND_START: begin
            due_we    = 1'b1;
            due_wdata = now_r;
            if (!walk_last) ptr_nxt = ptr_inc;
          end
          default: begin
            hold_valid_nxt = 1'b1;
            hold_ent_nxt   = ent_rdata;
            hold_slot_nxt  = idx_r;
          end
        endcase
      end
      ccts_pkg::ST_FLUSH: begin
        if (hold_valid_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_ent_nxt    = hold_ent_r;
          out_slot_nxt   = hold_slot_r;
          out_last_nxt   = 1'b1;
          hold_valid_nxt = 1'b0;
        end
      end
      default: begin
        hold_valid_nxt = 1'b0;
      end
    endcase

    // a port write also drops cyclic sending
    if (cfg_we) begin
      port_open_nxt = cfg_wdata;
      sending_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ccts_pkg::ST_IDLE;
      count_r      <= '0;
      sending_r    <= 1'b0;
      port_open_r  <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      ptr_r        <= '0;
      kind_r       <= ccts_pkg::KIND_TICK;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      sending_r    <= sending_nxt;
      port_open_r  <= port_open_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      ptr_r        <= ptr_nxt;
      kind_r       <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    now_r       <= now_nxt;
    ent_r       <= ent_nxt;
    hold_ent_r  <= hold_ent_nxt;
    hold_slot_r <= hold_slot_nxt;
    out_ent_r   <= out_ent_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  ccts_ram #(.WIDTH(ccts_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (raddr),
    .rdata (ent_rdata)
  );

  ccts_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH)) u_due_ram (
    .clk   (clk),
    .we    (due_we),
    .waddr (due_waddr),
    .wdata (due_wdata),
    .raddr (raddr),
    .rdata (due_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_slot     = out_slot_r;
  assign out_id       = out_ent_r.id;
  assign out_extended = out_ent_r.ext;
  assign out_remote   = out_ent_r.rtr;
  assign out_fd       = out_ent_r.fd;
  assign out_brs      = out_ent_r.brs;
  assign out_dlc_code = out_ent_r.fd ? ccts_pkg::len_to_code(out_ent_r.len) : out_ent_r.len;
  assign out_length   = out_ent_r.len;
  assign out_last     = out_last_r;

endmodule
`default_nettype wire

FILE: design/ccts_checker.sv
// port-level checks for the cyclic can transmit scheduler
// depends on ccts_pkg; bound to can_cyclic_tx_scheduler
`timescale 1ns / 1ps
`default_nettype none
module ccts_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [2:0] in_kind,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] out_slot,
  input wire logic       out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot) && $stable(out_last))
    else $error("stalled result changed");

  // results are only produced while a command is being worked
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // a non-final frame means the walk is still running
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("non-final frame without a running command");

  // stop finishes in its accept cycle
  a_stop_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == ccts_pkg::KIND_STOP |=> !in_stall)
    else $error("stop did not return to idle");

endmodule

bind can_cyclic_tx_scheduler ccts_checker u_ccts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_kind   (in_kind),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_slot  (out_slot),
  .out_last  (out_last)
);
`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench for the cyclic can transmit scheduler
// depends on ccts_pkg and can_cyclic_tx_scheduler; a scoreboard class predicts
// the frames of each accepted command and checks every frame the block emits
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int unsigned DEPTH = ccts_pkg::TABLE_DEPTH;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [47:0] TIME_TOP = 48'hFFFF_FFFF_FFFE;

  typedef struct {
    ccts_pkg::kind_t kind;
    logic [3:0]  idx;
    logic [47:0] now;
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    logic        fd;
    logic        brs;
    logic [6:0]  len;
    logic [15:0] period;
    logic        paused;
  } command_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    logic        fd;
    logic        brs;
    logic [6:0]  dlc;
    logic [6:0]  len;
    logic        last;
  } frame_t;

  // predicts emitted frames from accepted commands and checks them in order
  class frame_scoreboard;
    ccts_pkg::entry_t slots[DEPTH];
    logic [47:0] due_at[DEPTH];
    int unsigned used;
    bit          sending;
    bit          port_open;
    frame_t      pending_q[$];
    int unsigned mismatches;
    int unsigned frames_checked;

    function void write_port(bit v);
      port_open = v;
      sending   = 1'b0;
    endfunction

    function logic [6:0] dlc_of(ccts_pkg::entry_t e);
      logic [6:0] c;
      if (!e.fd || e.len <= 7'd8) c = e.len;
      else if (e.len <= 7'd12) c = 7'd9;
      else if (e.len <= 7'd16) c = 7'd10;
      else if (e.len <= 7'd20) c = 7'd11;
      else if (e.len <= 7'd24) c = 7'd12;
      else if (e.len <= 7'd32) c = 7'd13;
      else if (e.len <= 7'd48) c = 7'd14;
      else c = 7'd15;
      return c;
    endfunction

    function void queue_frame(int unsigned i);
      frame_t f;
      f.slot = i[3:0];
      f.id   = slots[i].id;
      f.ext  = slots[i].ext;
      f.rtr  = slots[i].rtr;
      f.fd   = slots[i].fd;
      f.brs  = slots[i].brs;
      f.dlc  = dlc_of(slots[i]);
      f.len  = slots[i].len;
      f.last = 1'b0;
      pending_q = {pending_q, f};
    endfunction

    function void note_command(command_t c);
      ccts_pkg::entry_t e;
      logic [48:0] sum;
      int unsigned depth_at_entry;
      depth_at_entry = pending_q.size();
      e.id     = c.id;
      e.ext    = c.ext;
      e.rtr    = c.rtr;
      e.fd     = c.fd;
      e.brs    = c.brs;
      e.len    = c.len;
      e.period = c.period;
      e.paused = c.paused;
      case (c.kind)
        ccts_pkg::KIND_TICK: if (port_open && sending) begin
          for (int unsigned i = 0; i < used; i++) begin
            if (slots[i].paused || c.now < due_at[i]) continue;
            queue_frame(i);
            sum = {1'b0, c.now} + slots[i].period;
            if (slots[i].period == 16'd0 || sum[48]) due_at[i] = '1;
            else due_at[i] = sum[47:0];
          end
        end
        ccts_pkg::KIND_ADD: if (used < DEPTH) begin
          slots[used]  = e;
          due_at[used] = '0;
          used++;
        end
        ccts_pkg::KIND_UPDATE: if (c.idx < used) begin
          slots[c.idx]  = e;
          due_at[c.idx] = '0;
        end
        ccts_pkg::KIND_REMOVE: if (c.idx < used) begin
          for (int unsigned i = c.idx; i + 1 < used; i++) begin
            slots[i]  = slots[i + 1];
            due_at[i] = due_at[i + 1];
          end
          used--;
        end
        ccts_pkg::KIND_CLEAR: used = 0;
        ccts_pkg::KIND_START: if (port_open && !sending) begin
          sending = 1'b1;
          for (int unsigned i = 0; i < used; i++) due_at[i] = c.now;
        end
        ccts_pkg::KIND_STOP: sending = 1'b0;
        ccts_pkg::KIND_SEND: if (port_open && c.idx < used) queue_frame(c.idx);
        default: ;
      endcase
      if (pending_q.size() > depth_at_entry) pending_q[pending_q.size() - 1].last = 1'b1;
    endfunction

    function bit check_frame(frame_t got);
      frame_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected frame %p", got);
        return 1'b0;
      end
      want = pending_q.pop_front();
      frames_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("frame mismatch\n  exp %p\n  got %p", want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_kind;
  logic [3:0]  in_entry_index;
  logic [47:0] in_now_ms;
  logic [28:0] in_can_id;
  logic        in_extended;
  logic        in_remote;
  logic        in_flexible_rate;
  logic        in_bit_rate_switch;
  logic [6:0]  in_byte_length;
  logic [15:0] in_period_ms;
  logic        in_paused;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_slot;
  logic [28:0] out_id;
  logic        out_extended;
  logic        out_remote;
  logic        out_fd;
  logic        out_brs;
  logic [6:0]  out_dlc_code;
  logic [6:0]  out_length;
  logic        out_last;
  logic        cfg_we;
  logic        cfg_wdata;

  frame_scoreboard sb;
  int unsigned items_sent;
  int unsigned idle_cycles;
  logic [47:0] clock_ms;     // running port time handed to ticks and starts
  bit          tx_busy_mode; // no idle gaps on the command side
  bit          rx_busy_mode; // no random stall on the frame side
  bit          hold_req;     // asks the receiver for one long hold-off

  can_cyclic_tx_scheduler uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_entry_index     (in_entry_index),
    .in_now_ms          (in_now_ms),
    .in_can_id          (in_can_id),
    .in_extended        (in_extended),
    .in_remote          (in_remote),
    .in_flexible_rate   (in_flexible_rate),
    .in_bit_rate_switch (in_bit_rate_switch),
    .in_byte_length     (in_byte_length),
    .in_period_ms       (in_period_ms),
    .in_paused          (in_paused),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_slot           (out_slot),
    .out_id             (out_id),
    .out_extended       (out_extended),
    .out_remote         (out_remote),
    .out_fd             (out_fd),
    .out_brs            (out_brs),
    .out_dlc_code       (out_dlc_code),
    .out_length         (out_length),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // frame monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      void'(sb.check_frame({out_slot, out_id, out_extended, out_remote, out_fd, out_brs,
                            out_dlc_code, out_length, out_last}));
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout, %0d frames still expected", sb.pending_q.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall outside busy mode, and one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (300) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= !rx_busy_mode && ($urandom_range(99) < 26);
    end
  end

  // build a command with random contents; the caller picks the kind
  function automatic command_t random_command(ccts_pkg::kind_t k);
    command_t c;
    c.kind   = k;
    c.idx    = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                        : 4'($urandom_range(sb.used));
    c.now    = clock_ms;
    c.id     = 29'($urandom);
    c.ext    = 1'($urandom_range(1));
    c.rtr    = 1'($urandom_range(1));
    c.fd     = 1'($urandom_range(1));
    c.brs    = 1'($urandom_range(1));
    c.len    = 7'($urandom_range(64));
    c.period = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(60));
    c.paused = ($urandom_range(99) < 15);
    return c;
  endfunction

  // offer one command and wait until it is accepted
  task automatic push_command(command_t c);
    if (!tx_busy_mode && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_kind            <= c.kind;
    in_entry_index     <= c.idx;
    in_now_ms          <= c.now;
    in_can_id          <= c.id;
    in_extended        <= c.ext;
    in_remote          <= c.rtr;
    in_flexible_rate   <= c.fd;
    in_bit_rate_switch <= c.brs;
    in_byte_length     <= c.len;
    in_period_ms       <= c.period;
    in_paused          <= c.paused;
    in_valid           <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_command(c);
    items_sent++;
    @(negedge clk);
  endtask

  // let the command side go quiet and every expected frame arrive
  task automatic drain;
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_port_open(bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_port(v);
    @(negedge clk);
  endtask

  task automatic command_of(ccts_pkg::kind_t k, logic [3:0] idx, logic [47:0] now);
    command_t c;
    c     = random_command(k);
    c.idx = idx;
    c.now = now;
    push_command(c);
  endtask

  task automatic random_commands(int unsigned count);
    command_t    c;
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40) begin
        clock_ms = clock_ms + $urandom_range(80);
        c = random_command(ccts_pkg::KIND_TICK);
      end else if (r < 58) c = random_command(ccts_pkg::KIND_ADD);
      else if (r < 68) c = random_command(ccts_pkg::KIND_UPDATE);
      else if (r < 78) c = random_command(ccts_pkg::KIND_REMOVE);
      else if (r < 88) c = random_command(ccts_pkg::KIND_SEND);
      else if (r < 93) c = random_command(ccts_pkg::KIND_START);
      else if (r < 97) c = random_command(ccts_pkg::KIND_STOP);
      else c = random_command(ccts_pkg::KIND_CLEAR);
      push_command(c);
    end
  endtask

  initial begin
    command_t c;
    bit       phase_port[6];
    sb = new();
    phase_port = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = ccts_pkg::KIND_TICK;
    in_entry_index = '0;
    in_now_ms = '0;
    in_can_id = '0;
    in_extended = 1'b0;
    in_remote = 1'b0;
    in_flexible_rate = 1'b0;
    in_bit_rate_switch = 1'b0;
    in_byte_length = '0;
    in_period_ms = '0;
    in_paused = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    items_sent = 0;
    clock_ms = 48'd100;
    tx_busy_mode = 1'b0;
    rx_busy_mode = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes of the entry fields and every fd length band
    write_port_open(1'b1);
    c = random_command(ccts_pkg::KIND_ADD);
    c.id = '1; c.ext = 1; c.rtr = 1; c.fd = 1; c.brs = 1;
    c.len = 7'd64; c.period = 16'd0; c.paused = 0;
    push_command(c);
    c.id = '0; c.ext = 0; c.rtr = 0; c.fd = 0; c.brs = 0;
    c.len = 7'd0; c.period = 16'hFFFF;
    push_command(c);
    for (int unsigned i = 0; i < 7; i++) begin
      c = random_command(ccts_pkg::KIND_ADD);
      c.fd = 1; c.paused = 0; c.period = 16'd5;
      c.len = (i == 0) ? 7'd8 : (i == 1) ? 7'd12 : (i == 2) ? 7'd16 : (i == 3) ? 7'd20
            : (i == 4) ? 7'd24 : (i == 5) ? 7'd32 : 7'd48;
      push_command(c);
    end
    command_of(ccts_pkg::KIND_SEND, 4'd0, clock_ms);         // send at once
    command_of(ccts_pkg::KIND_SEND, 4'd15, clock_ms);        // index out of range
    command_of(ccts_pkg::KIND_TICK, 4'd0, 48'd100);          // not started yet
    command_of(ccts_pkg::KIND_START, 4'd0, 48'd100);
    command_of(ccts_pkg::KIND_START, 4'd0, 48'd500);         // refused, already sending
    command_of(ccts_pkg::KIND_TICK, 4'd0, 48'd100);          // everything due
    command_of(ccts_pkg::KIND_TICK, 4'd0, 48'd105);          // only the entries with period 5
    c = random_command(ccts_pkg::KIND_UPDATE);
    c.idx = 4'd2; c.paused = 1;
    push_command(c);                                         // paused entry
    command_of(ccts_pkg::KIND_REMOVE, 4'd0, clock_ms);
    command_of(ccts_pkg::KIND_REMOVE, 4'd15, clock_ms);      // out of range
    command_of(ccts_pkg::KIND_TICK, 4'd0, TIME_TOP - 48'd3); // reschedule saturates
    command_of(ccts_pkg::KIND_TICK, 4'd0, TIME_TOP);
    command_of(ccts_pkg::KIND_STOP, 4'd0, clock_ms);
    command_of(ccts_pkg::KIND_TICK, 4'd0, TIME_TOP);         // stopped
    command_of(ccts_pkg::KIND_CLEAR, 4'd0, clock_ms);

    // random phases, each under its own port setting
    for (int unsigned p = 0; p < 6; p++) begin
      drain();
      write_port_open(phase_port[p]);
      tx_busy_mode = (p == 0);
      rx_busy_mode = (p == 0);
      if (p == 4) clock_ms = TIME_TOP - 48'd2000;  // late in the time range
      if (p == 5) clock_ms = 48'd0;
      command_of(ccts_pkg::KIND_START, 4'd0, clock_ms);
      random_commands(22);
      if (p == 2) begin
        // long receiver hold-off while ticks keep coming
        hold_req = 1'b1;
        repeat (6) begin
          c = random_command(ccts_pkg::KIND_ADD);
          c.paused = 0;
          push_command(c);
        end
        repeat (14) begin
          clock_ms = clock_ms + 48'd1000;
          command_of(ccts_pkg::KIND_TICK, 4'd0, clock_ms);
        end
      end
      if (p == 3) begin
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge clk);
      end
      random_commands(22);
    end

    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d commands sent over six port phases, %0d frames checked",
             items_sent, sb.frames_checked);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
